// ===== sv/lcic_pkg.sv =====
// ----------------------------------------------------------------------------
// lcic_pkg
// Types and constants shared by the line compare front, queue and back.
// ----------------------------------------------------------------------------
package lcic_pkg;

	localparam int CFG_INDEX_W     = 2;
	localparam int CFG_DATA_W      = 64;
	localparam int NUM_IGNORE_REGS = 4;
	localparam int QUEUE_DEPTH     = 2;
	localparam int KEPT_W          = 32;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_LINE   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [7:0] CR_BYTE   = 8'h0D;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic              line_differs;
		logic [KEPT_W-1:0] kept_lines;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_CLEAR,
		OP_CMP,
		OP_SKIP,
		OP_CUT
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] data_byte;
		logic       last_byte;
	} op_t;

endpackage

// ===== sv/lcic_front.sv =====
// ----------------------------------------------------------------------------
// lcic_front
// Holds the ignore set and classifies each accepted item into a queue op.
// ----------------------------------------------------------------------------
module lcic_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lcic_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lcic_pkg::in_item_t             in_item,
	output logic                           push_valid,
	input  logic                           push_ready,
	output lcic_pkg::op_t                  push_op
);

	logic [lcic_pkg::NUM_IGNORE_REGS-1:0][lcic_pkg::CFG_DATA_W-1:0] ignore_q;
	logic is_ignored;
	logic is_cut;
	logic keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q <= '0;
		end else if (cfg_we) begin
			ignore_q[cfg_index] <= cfg_data;
		end
	end

	assign is_ignored = ignore_q[in_item.data_byte[7:6]][in_item.data_byte[5:0]];
	assign is_cut     = (in_item.data_byte == lcic_pkg::CR_BYTE) ||
	                    (in_item.data_byte == lcic_pkg::ZERO_BYTE);

	always_comb begin
		keep                = 1'b0;
		push_op.kind        = lcic_pkg::OP_SKIP;
		push_op.data_byte   = in_item.data_byte;
		push_op.last_byte   = in_item.last_byte;
		case (in_item.func)
			lcic_pkg::FUNC_APPEND: begin
				push_op.kind = lcic_pkg::OP_APPEND;
				keep         = (in_item.data_byte != lcic_pkg::ZERO_BYTE) && !is_ignored;
			end
			lcic_pkg::FUNC_LINE: begin
				keep = 1'b1;
				if (is_cut) begin
					push_op.kind = lcic_pkg::OP_CUT;
				end else if (is_ignored) begin
					push_op.kind = lcic_pkg::OP_SKIP;
				end else begin
					push_op.kind = lcic_pkg::OP_CMP;
				end
			end
			lcic_pkg::FUNC_CLEAR: begin
				push_op.kind = lcic_pkg::OP_CLEAR;
				keep         = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// dropped items are taken only when the queue has room, keeping order simple
	assign in_ready   = push_ready;
	assign push_valid = in_valid && keep;

endmodule

// ===== sv/lcic_queue.sv =====
// ----------------------------------------------------------------------------
// lcic_queue
// Short queue of classified ops between the front and the back.
// ----------------------------------------------------------------------------
module lcic_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lcic_pkg::op_t push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output lcic_pkg::op_t pop_op
);

	localparam int PW = (lcic_pkg::QUEUE_DEPTH > 1) ? $clog2(lcic_pkg::QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(lcic_pkg::QUEUE_DEPTH + 1);

	lcic_pkg::op_t slot_q [lcic_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(lcic_pkg::QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_op     = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(lcic_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(lcic_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lcic_back.sv =====
// ----------------------------------------------------------------------------
// lcic_back
// Pattern store, line match state, differing line count and output register.
// ----------------------------------------------------------------------------
module lcic_back #(
	parameter int PATTERN_MAX = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  lcic_pkg::op_t      op,
	output logic               out_valid,
	input  logic               out_ready,
	output lcic_pkg::out_item_t out_item
);

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [7:0]              mem [PATTERN_MAX];
	logic [7:0]              rdata_q;
	logic [LW-1:0]           len_q, len_n;
	logic [LW-1:0]           mp_q, mp_n, mp_line;
	logic                    too_long_q, too_long_n;
	logic                    mis_q, mis_n, mis_line;
	logic                    cut_q, cut_n;
	logic [lcic_pkg::KEPT_W-1:0] kept_q, kept_n;
	logic                    out_valid_q;
	lcic_pkg::out_item_t     out_q;
	lcic_pkg::out_item_t     res;
	logic                    is_result;
	logic                    pop;
	logic                    we;
	logic [AW-1:0]           raddr;
	logic                    differs;

	assign is_result = op.last_byte && (op.kind inside {lcic_pkg::OP_CMP, lcic_pkg::OP_SKIP,
	                                                     lcic_pkg::OP_CUT});
	assign pop       = op_valid && (!is_result || !out_valid_q || out_ready);
	assign op_ready  = pop;

	always_comb begin
		len_n      = len_q;
		too_long_n = too_long_q;
		mp_n       = mp_q;
		mis_n      = mis_q;
		cut_n      = cut_q;
		kept_n     = kept_q;
		mp_line    = mp_q;
		mis_line   = mis_q;
		we         = 1'b0;
		differs    = 1'b0;
		case (op.kind)
			lcic_pkg::OP_APPEND: begin
				if (len_q < LW'(PATTERN_MAX)) begin
					we    = pop;
					len_n = len_q + 1'b1;
				end else begin
					too_long_n = 1'b1;
				end
			end
			lcic_pkg::OP_CLEAR: begin
				len_n      = '0;
				too_long_n = 1'b0;
				kept_n     = '0;
				mp_n       = '0;
				mis_n      = 1'b0;
				cut_n      = 1'b0;
			end
			lcic_pkg::OP_CMP, lcic_pkg::OP_SKIP, lcic_pkg::OP_CUT: begin
				if (!cut_q) begin
					if (op.kind == lcic_pkg::OP_CUT) begin
						cut_n = 1'b1;
					end else if (op.kind == lcic_pkg::OP_CMP) begin
						if ((mp_q < len_q) && (rdata_q == op.data_byte)) begin
							mp_line = mp_q + 1'b1;
						end else begin
							mis_line = 1'b1;
						end
					end
				end
				mp_n  = mp_line;
				mis_n = mis_line;
				if (op.last_byte) begin
					differs = too_long_q || mis_line || (mp_line != len_q);
					if (differs && (kept_q != '1)) begin
						kept_n = kept_q + 1'b1;
					end
					mp_n  = '0;
					mis_n = 1'b0;
					cut_n = 1'b0;
				end
			end
			default: begin
			end
		endcase
		res.line_differs = differs;
		res.kept_lines   = kept_n;
	end

	// read the entry for the next position so it is ready for the next byte
	assign raddr = pop ? mp_n[AW-1:0] : mp_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[len_q[AW-1:0]] <= op.data_byte;
		end
		if (we && (len_q[AW-1:0] == raddr)) begin
			rdata_q <= op.data_byte;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			too_long_q <= 1'b0;
			mp_q       <= '0;
			mis_q      <= 1'b0;
			cut_q      <= 1'b0;
			kept_q     <= '0;
		end else if (pop) begin
			len_q      <= len_n;
			too_long_q <= too_long_n;
			mp_q       <= mp_n;
			mis_q      <= mis_n;
			cut_q      <= cut_n;
			kept_q     <= kept_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && is_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_result) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(PATTERN_MAX))
		else $error("pattern length beyond store depth");

	a_mp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mp_q <= len_q)
		else $error("match position past pattern length");

	a_too_long_full: assert property (@(posedge clk) disable iff (!arst_n)
		too_long_q |-> (len_q == LW'(PATTERN_MAX)))
		else $error("overflow flag with store not full");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("pending result lost or changed while stalled");

endmodule

// ===== sv/line_compare_ignoring_charset_core.sv =====
// ----------------------------------------------------------------------------
// line_compare_ignoring_charset_core
// Line filter comparing text lines to a stored pattern modulo an ignore set.
// A line's result is registered in the back after its last byte passes the queue.
// Throughput: one item per cycle, one store read and compare per byte; a held
// result fills the two-entry queue and then drops in_ready.
// Reset clears the ignore set, pattern length, line state, count and queue;
// the pattern store itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module line_compare_ignoring_charset_core #(
	parameter int PATTERN_MAX = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcic_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  lcic_pkg::in_item_t               in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output lcic_pkg::out_item_t              out_item
);

	logic          push_valid;
	logic          push_ready;
	lcic_pkg::op_t push_op;
	logic          pop_valid;
	logic          pop_ready;
	lcic_pkg::op_t pop_op;

	lcic_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op)
	);

	lcic_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_op    (push_op),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_op     (pop_op)
	);

	lcic_back #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (pop_valid),
		.op_ready  (pop_ready),
		.op        (pop_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/line_filter_checker.sv =====
// ----------------------------------------------------------------------------
// line_filter_checker
// Watches the configuration port and both item channels of the line compare
// core. It keeps its own copy of the ignore set, the pattern store and the
// per-line compare state, and works out the verdict of every finished line.
// Each result item is compared field by field with the oldest verdict still
// due. The number of failures and of verdicts still due go to the top.
// ----------------------------------------------------------------------------
module line_filter_checker #(
	parameter int PATTERN_MAX = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcic_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lcic_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  lcic_pkg::in_item_t               in_item,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  lcic_pkg::out_item_t              out_item,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [lcic_pkg::CFG_DATA_W-1:0] ignore_set [lcic_pkg::NUM_IGNORE_REGS];
	logic [7:0]                      pat_mem [PATTERN_MAX];
	int                              pat_len;
	logic                            pat_overflow;
	int                              match_at;
	logic                            saw_mismatch;
	logic                            cut_seen;
	logic [lcic_pkg::KEPT_W-1:0]     differ_count;
	lcic_pkg::out_item_t             due_verdicts [$];
	lcic_pkg::out_item_t             oldest;

	function automatic logic byte_ignored(input logic [7:0] b);
		return ignore_set[b[7:6]][b[5:0]];
	endfunction

	task automatic restart_line();
		match_at = 0;
		saw_mismatch = 1'b0;
		cut_seen = 1'b0;
	endtask

	task automatic advance_filter(input lcic_pkg::in_item_t it);
		lcic_pkg::out_item_t verdict;
		logic differs;
		case (it.func)
			lcic_pkg::FUNC_APPEND: begin
				if (it.data_byte != lcic_pkg::ZERO_BYTE && !byte_ignored(it.data_byte)) begin
					if (pat_len < PATTERN_MAX) begin
						pat_mem[pat_len] = it.data_byte;
						pat_len++;
					end else begin
						pat_overflow = 1'b1;
					end
				end
			end
			lcic_pkg::FUNC_CLEAR: begin
				pat_len = 0;
				pat_overflow = 1'b0;
				differ_count = '0;
				restart_line();
			end
			lcic_pkg::FUNC_LINE: begin
				if (!cut_seen) begin
					if (it.data_byte == lcic_pkg::CR_BYTE ||
					    it.data_byte == lcic_pkg::ZERO_BYTE) begin
						cut_seen = 1'b1;
					end else if (!byte_ignored(it.data_byte)) begin
						if (match_at < pat_len && pat_mem[match_at] == it.data_byte)
							match_at++;
						else
							saw_mismatch = 1'b1;
					end
				end
				if (it.last_byte) begin
					differs = pat_overflow || saw_mismatch || (match_at != pat_len);
					if (differs && differ_count != '1)
						differ_count++;
					verdict.line_differs = differs;
					verdict.kept_lines = differ_count;
					due_verdicts.push_back(verdict);
					restart_line();
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ignore_set[i])
				ignore_set[i] = '0;
			pat_len = 0;
			pat_overflow = 1'b0;
			differ_count = '0;
			restart_line();
			due_verdicts.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				ignore_set[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				advance_filter(in_item);
			if (out_valid && out_ready) begin
				if (due_verdicts.size() == 0) begin
					$error("unexpected result item: line_differs %0d kept_lines %0d",
						out_item.line_differs, out_item.kept_lines);
					fail_count++;
				end else begin
					oldest = due_verdicts.pop_front();
					if (out_item.line_differs !== oldest.line_differs) begin
						$error("line_differs expected %0d actual %0d",
							oldest.line_differs, out_item.line_differs);
						fail_count++;
					end
					if (out_item.kept_lines !== oldest.kept_lines) begin
						$error("kept_lines expected %0d actual %0d",
							oldest.kept_lines, out_item.kept_lines);
						fail_count++;
					end
				end
			end
			pending = due_verdicts.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the line compare core: a directed pass over patterns, cut
// lines, zero bytes and the unused selector, a full-length and overflowing
// pattern, then random phases under changing ignore sets, mostly lines built
// from the loaded pattern with ignored bytes mixed in and small mutations.
// Both channels idle in random bursts; checking is done by the checker.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         PATTERN_MAX  = 256;
	localparam int         RANDOM_ITEMS = 160;
	localparam int         CALM_ITEMS   = 60;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         CYCLE_LIMIT  = 400000;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [lcic_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [lcic_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	lcic_pkg::in_item_t               in_item = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	lcic_pkg::out_item_t              out_item;
	int unsigned                      fail_count;
	int unsigned                      pending;

	logic [lcic_pkg::CFG_DATA_W-1:0] skip_set [lcic_pkg::NUM_IGNORE_REGS];
	logic [7:0]                      pat_bytes [$];
	int                              items_sent = 0;
	int                              gap_pct = 20;
	int                              stall_pct = 20;
	int                              stall_left = 0;
	int                              cycle_count = 0;

	always #4 clk = ~clk;

	line_compare_ignoring_charset_core #(
		.PATTERN_MAX(PATTERN_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	line_filter_checker #(
		.PATTERN_MAX(PATTERN_MAX)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.fail_count(fail_count),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic is_skipped(input logic [7:0] b);
		return skip_set[b[7:6]][b[5:0]];
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] pick_kept();
		logic [7:0] b;
		b = 8'($urandom_range(1, 255));
		for (int n = 0; n < 64; n++) begin
			if (b != lcic_pkg::CR_BYTE && !is_skipped(b))
				return b;
			b = 8'($urandom_range(1, 255));
		end
		return b;
	endfunction

	task automatic pick_ignored(output logic hit, output logic [7:0] b);
		hit = 1'b0;
		b = 8'($urandom_range(1, 255));
		for (int n = 0; n < 32 && !hit; n++) begin
			if (is_skipped(b))
				hit = 1'b1;
			else
				b = 8'($urandom_range(1, 255));
		end
	endtask

	task automatic send_item(input logic [1:0] func, input logic [7:0] data, input logic last);
		logic took;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{func: func, data_byte: data, last_byte: last};
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		if (func != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_skip_set();
		for (int i = 0; i < lcic_pkg::NUM_IGNORE_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= lcic_pkg::CFG_INDEX_W'(i);
			cfg_data <= skip_set[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic load_pattern(input int len);
		logic [7:0] b;
		logic hit;
		send_item(lcic_pkg::FUNC_CLEAR, 8'($urandom_range(1, 255)), 1'($urandom));
		pat_bytes.delete();
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				pick_ignored(hit, b);
				if (hit)
					send_item(lcic_pkg::FUNC_APPEND, b, 1'($urandom));
			end
			b = pick_kept();
			send_item(lcic_pkg::FUNC_APPEND, b, 1'($urandom));
			if (!is_skipped(b))
				pat_bytes.push_back(b);
		end
	endtask

	// shape 0 is an exact line, shapes 1 to 4 are mutations of it, shape 5 is random bytes
	task automatic send_line(input int shape);
		logic [7:0] seq [$];
		logic [7:0] b;
		logic hit;
		int k;
		foreach (pat_bytes[i]) begin
			if ($urandom_range(0, 4) == 0) begin
				pick_ignored(hit, b);
				if (hit)
					seq.push_back(b);
			end
			seq.push_back(pat_bytes[i]);
		end
		case (shape)
			1: if (seq.size() > 0) seq[$urandom_range(0, seq.size() - 1)] = pick_kept();
			2: if (seq.size() > 0) seq.delete($urandom_range(0, seq.size() - 1));
			3: seq.insert($urandom_range(0, seq.size()), pick_kept());
			4: begin
				k = $urandom_range(0, seq.size());
				seq.insert(k, lcic_pkg::CR_BYTE);
				repeat ($urandom_range(0, 3)) seq.push_back(8'($urandom_range(1, 255)));
			end
			5: begin
				seq.delete();
				repeat ($urandom_range(1, 8)) seq.push_back(8'($urandom_range(1, 255)));
			end
			default: begin
			end
		endcase
		if (seq.size() == 0)
			seq.push_back(lcic_pkg::CR_BYTE);
		foreach (seq[i])
			send_item(lcic_pkg::FUNC_LINE, seq[i], i == seq.size() - 1);
	endtask

	initial begin
		int base;
		int phase;
		int r;
		int kind;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (skip_set[i])
			skip_set[i] = '0;
		write_skip_set();

		// pattern 61 ff 63, zero byte dropped
		send_item(lcic_pkg::FUNC_APPEND, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_APPEND, lcic_pkg::ZERO_BYTE, 1'b0);
		send_item(lcic_pkg::FUNC_APPEND, 8'hFF, 1'b0);
		send_item(lcic_pkg::FUNC_APPEND, 8'h63, 1'b1);
		send_item(FUNC_UNUSED, 8'h61, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'hFF, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h63, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h01, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h63, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'hFF, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'hFF, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h63, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, lcic_pkg::CR_BYTE, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h7F, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h61, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, lcic_pkg::ZERO_BYTE, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, 8'h80, 1'b1);
		send_item(lcic_pkg::FUNC_CLEAR, 8'h55, 1'b0);
		send_item(lcic_pkg::FUNC_LINE, lcic_pkg::CR_BYTE, 1'b1);
		send_item(lcic_pkg::FUNC_LINE, 8'h80, 1'b1);

		// full store, ignored byte at full, exact full line, then overflow
		wait_idle();
		skip_set[0][6'h20] = 1'b1;
		write_skip_set();
		load_pattern(PATTERN_MAX);
		send_item(lcic_pkg::FUNC_APPEND, 8'h20, 1'b0);
		send_line(0);
		send_item(lcic_pkg::FUNC_APPEND, 8'hC3, 1'b0);
		send_line(5);
		send_item(lcic_pkg::FUNC_CLEAR, 8'hAA, 1'b1);
		pat_bytes.delete();

		base = items_sent;
		phase = 0;
		while (items_sent - base < RANDOM_ITEMS) begin
			wait_idle();
			if (items_sent - base >= RANDOM_ITEMS - CALM_ITEMS) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
				stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 35);
			end
			kind = (phase == 0) ? 1 : (phase == 1) ? 0 : $urandom_range(0, 5);
			foreach (skip_set[i]) begin
				case (kind)
					0: skip_set[i] = '0;
					1: skip_set[i] = '1;
					2: skip_set[i] = rand_word();
					default: skip_set[i] = rand_word() & rand_word() & rand_word();
				endcase
			end
			if (kind == 4) begin
				foreach (skip_set[i])
					skip_set[i] = '0;
				skip_set[$urandom_range(0, lcic_pkg::NUM_IGNORE_REGS - 1)] = '1;
			end else if (kind == 5) begin
				skip_set[0][lcic_pkg::CR_BYTE[5:0]] = 1'b1;
			end
			write_skip_set();
			if (phase < 2 || $urandom_range(0, 3) != 0)
				load_pattern($urandom_range(0, 12));
			repeat ($urandom_range(4, 8)) begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					send_line(0);
				end else if (r < 85) begin
					send_line($urandom_range(1, 5));
				end else if (r < 90) begin
					send_item(FUNC_UNUSED, 8'($urandom_range(1, 255)), 1'($urandom));
				end else if (r < 94) begin
					// clear abandons a line in progress
					repeat ($urandom_range(1, 3))
						send_item(lcic_pkg::FUNC_LINE, 8'($urandom_range(1, 255)), 1'b0);
					send_item(lcic_pkg::FUNC_CLEAR, 8'($urandom_range(1, 255)), 1'($urandom));
					pat_bytes.delete();
				end else if (r < 97) begin
					load_pattern($urandom_range(0, 8));
				end else begin
					wait_idle();
				end
			end
			phase++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES * 4) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
